/* rtl/cdq_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package cdq_pkg;

  // Store geometry.
  localparam int DEPTH   = 1024;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int CAP_W   = ADDR_W + 1;
  localparam int DATA_W  = 32;

  // Result beat layout: popped, head, tail, empty flag, padded to whole bytes.
  localparam int RES_BITS = 3 * DATA_W + 1;
  localparam int M_DATA_W = ((RES_BITS + 7) / 8) * 8;

  // Request kinds.
  localparam logic [1:0] REQ_PUSH_REAR  = 2'd0;
  localparam logic [1:0] REQ_PUSH_FRONT = 2'd1;
  localparam logic [1:0] REQ_POP_FRONT  = 2'd2;
  localparam logic [1:0] REQ_POP_REAR   = 2'd3;

  // Result status codes.
  localparam logic [1:0] STAT_DONE  = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

endpackage

`default_nettype wire

/* rtl/circular_deque.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Width  Contents
// s_tdata   in   32     push_value
// s_tuser   in   2      req_type
// m_tdata   out  104    popped_value, head_value, tail_value, now_empty, zero pad
// m_tuser   out  2      status
// cfg_*     in   11     capacity (write only, empties the deque)
//
// A request's accept cycle updates the pointers and writes the store, and the
// next cycle takes the registered store read that refreshes the cached head
// or tail word after a pop.
// Only one request is in flight, so a store read never meets a write to the
// same entry. The next request is taken while a result waits on m_tdata.
// Reset is synchronous; it empties the deque and sets the capacity to 1024.
// The store itself is not cleared.

module circular_deque
  import cdq_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_we,
  input  wire logic [CAP_W-1:0]    cfg_data,
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  input  wire logic [DATA_W-1:0]   s_tdata,   // [31:0] push_value
  input  wire logic [1:0]          s_tuser,   // [1:0] req_type
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  output logic [M_DATA_W-1:0]      m_tdata,   // [31:0] popped, [63:32] head,
                                              // [95:64] tail, [96] now_empty
  output logic [1:0]               m_tuser    // [1:0] status
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_BUSY = 2'd1;
  localparam logic [1:0] ST_HOLD = 2'd2;

  logic [1:0]          state, state_next;
  logic [ADDR_W-1:0]   head_idx, head_idx_next;
  logic [ADDR_W-1:0]   tail_idx, tail_idx_next;
  logic                empty_mark, empty_mark_next;
  logic [CAP_W-1:0]    capacity;
  logic [DATA_W-1:0]   head_val, head_val_next;
  logic [DATA_W-1:0]   tail_val, tail_val_next;
  logic [1:0]          op_status, op_status_next;
  logic [DATA_W-1:0]   op_popped, op_popped_next;
  logic                rd_head, rd_head_next;
  logic                rd_tail, rd_tail_next;
  logic [M_DATA_W-1:0] hold_data, hold_data_next;
  logic                m_tvalid_next;
  logic [M_DATA_W-1:0] m_tdata_next;
  logic [1:0]          m_tuser_next;

  logic [CAP_W-1:0]    cap_eff;
  logic [CAP_W-1:0]    cap_m1;
  logic [ADDR_W-1:0]   cap_last;
  logic [ADDR_W-1:0]   tail_fwd, head_fwd, tail_back, head_back;
  logic                accept;
  logic                full;
  logic                out_free;
  logic [M_DATA_W-1:0] result;

  logic [DATA_W-1:0]   slot_mem [DEPTH];
  logic                mem_we, mem_re;
  logic [ADDR_W-1:0]   mem_waddr, mem_raddr;
  logic [DATA_W-1:0]   rd_data;

  // Capacity in use, clamped between one and the store size, and its last index.
  always_comb begin
    if (capacity == '0) begin
      cap_eff = CAP_W'(1);
    end else if (capacity > CAP_W'(DEPTH)) begin
      cap_eff = CAP_W'(DEPTH);
    end else begin
      cap_eff = capacity;
    end
    cap_m1   = cap_eff - CAP_W'(1);
    cap_last = cap_m1[ADDR_W-1:0];
  end

  // Neighbor indices with wrap at the capacity in use.
  assign tail_fwd  = (tail_idx >= cap_last) ? '0 : tail_idx + ADDR_W'(1);
  assign head_fwd  = (head_idx >= cap_last) ? '0 : head_idx + ADDR_W'(1);
  assign tail_back = (tail_idx == '0) ? cap_last : tail_idx - ADDR_W'(1);
  assign head_back = (head_idx == '0) ? cap_last : head_idx - ADDR_W'(1);

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign full     = !empty_mark && (tail_fwd == head_idx);
  assign out_free = !m_tvalid || m_tready;

  // Request handling, cache refresh and result hand-off.
  always_comb begin
    state_next      = state;
    head_idx_next   = head_idx;
    tail_idx_next   = tail_idx;
    empty_mark_next = empty_mark;
    head_val_next   = head_val;
    tail_val_next   = tail_val;
    op_status_next  = op_status;
    op_popped_next  = op_popped;
    rd_head_next    = rd_head;
    rd_tail_next    = rd_tail;
    hold_data_next  = hold_data;
    m_tvalid_next   = m_tvalid && !m_tready;
    m_tdata_next    = m_tdata;
    m_tuser_next    = m_tuser;
    mem_we          = 1'b0;
    mem_re          = 1'b0;
    mem_waddr       = '0;
    mem_raddr       = '0;
    result          = '0;

    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next     = ST_BUSY;
          op_status_next = STAT_DONE;
          op_popped_next = '0;
          rd_head_next   = 1'b0;
          rd_tail_next   = 1'b0;
          if (s_tuser == REQ_PUSH_REAR || s_tuser == REQ_PUSH_FRONT) begin
            if (full) begin
              op_status_next = STAT_FULL;
            end else if (empty_mark) begin
              head_idx_next   = '0;
              tail_idx_next   = '0;
              empty_mark_next = 1'b0;
              head_val_next   = s_tdata;
              tail_val_next   = s_tdata;
              mem_we          = 1'b1;
              mem_waddr       = '0;
            end else if (s_tuser == REQ_PUSH_REAR) begin
              tail_idx_next = tail_fwd;
              tail_val_next = s_tdata;
              mem_we        = 1'b1;
              mem_waddr     = tail_fwd;
            end else begin
              head_idx_next = head_back;
              head_val_next = s_tdata;
              mem_we        = 1'b1;
              mem_waddr     = head_back;
            end
          end else begin
            if (empty_mark) begin
              op_status_next = STAT_EMPTY;
            end else begin
              op_popped_next = (s_tuser == REQ_POP_FRONT) ? head_val : tail_val;
              if (head_idx == tail_idx) begin
                head_idx_next   = '0;
                tail_idx_next   = '0;
                empty_mark_next = 1'b1;
              end else if (s_tuser == REQ_POP_FRONT) begin
                head_idx_next = head_fwd;
                rd_head_next  = 1'b1;
                mem_re        = 1'b1;
                mem_raddr     = head_fwd;
              end else begin
                tail_idx_next = tail_back;
                rd_tail_next  = 1'b1;
                mem_re        = 1'b1;
                mem_raddr     = tail_back;
              end
            end
          end
        end
      end
      ST_BUSY: begin
        if (rd_head) begin
          head_val_next = rd_data;
        end
        if (rd_tail) begin
          tail_val_next = rd_data;
        end
        result[DATA_W-1:0]          = op_popped;
        result[2*DATA_W-1:DATA_W]   = empty_mark ? '0 : head_val_next;
        result[3*DATA_W-1:2*DATA_W] = empty_mark ? '0 : tail_val_next;
        result[3*DATA_W]            = empty_mark;
        hold_data_next              = result;
        if (out_free) begin
          m_tvalid_next = 1'b1;
          m_tdata_next  = result;
          m_tuser_next  = op_status;
          state_next    = ST_IDLE;
        end else begin
          state_next = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          m_tvalid_next = 1'b1;
          m_tdata_next  = hold_data;
          m_tuser_next  = op_status;
          state_next    = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    // A capacity write empties the deque.
    if (cfg_we) begin
      head_idx_next   = '0;
      tail_idx_next   = '0;
      empty_mark_next = 1'b1;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      head_idx   <= '0;
      tail_idx   <= '0;
      empty_mark <= 1'b1;
      capacity   <= CAP_W'(DEPTH);
      m_tvalid   <= 1'b0;
      rd_head    <= 1'b0;
      rd_tail    <= 1'b0;
    end else begin
      state      <= state_next;
      head_idx   <= head_idx_next;
      tail_idx   <= tail_idx_next;
      empty_mark <= empty_mark_next;
      m_tvalid   <= m_tvalid_next;
      rd_head    <= rd_head_next;
      rd_tail    <= rd_tail_next;
      if (cfg_we) begin
        capacity <= cfg_data;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    head_val  <= head_val_next;
    tail_val  <= tail_val_next;
    op_status <= op_status_next;
    op_popped <= op_popped_next;
    hold_data <= hold_data_next;
    m_tdata   <= m_tdata_next;
    m_tuser   <= m_tuser_next;
  end

  // Word store with one write port and a registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem[mem_waddr] <= s_tdata;
    end
    if (mem_re) begin
      rd_data <= slot_mem[mem_raddr];
    end
  end

  // An empty deque always has both indices parked at zero.
  a_empty_idx: assert property (@(posedge clk) disable iff (rst)
    empty_mark |-> (head_idx == '0 && tail_idx == '0))
    else $error("empty deque with nonzero indices");

  // Indices stay inside the capacity in use.
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    (head_idx <= cap_last && tail_idx <= cap_last))
    else $error("index beyond capacity");

  // Only one request is in flight at a time.
  a_one_flight: assert property (@(posedge clk) disable iff (rst)
    accept |=> !s_tready)
    else $error("request taken while another is in flight");

  // An empty result carries zero head and tail words.
  a_empty_words: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[3*DATA_W]) |-> (m_tdata[3*DATA_W-1:DATA_W] == '0))
    else $error("empty result with nonzero head or tail");

  // A refused request pops nothing.
  a_refused_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != STAT_DONE) |-> (m_tdata[DATA_W-1:0] == '0))
    else $error("refused request with nonzero popped word");

endmodule

`default_nettype wire

/* test/circular_deque_tb.sv */
`timescale 1ns / 1ps

module circular_deque_tb;
  import cdq_pkg::*;

  // One result beat as the deque should report it.
  typedef struct packed {
    logic [1:0]        status;
    logic [DATA_W-1:0] popped;
    logic [DATA_W-1:0] head;
    logic [DATA_W-1:0] tail;
    logic              empty;
  } deque_result_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_we = 1'b0;
  logic [CAP_W-1:0]    cfg_data = '0;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [DATA_W-1:0]   s_tdata = '0;
  logic [1:0]          s_tuser = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;
  logic [1:0]          m_tuser;

  circular_deque uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // Shadow copy of the deque state.
  logic [DATA_W-1:0] shadow_slots [DEPTH];
  int                head_idx = 0;
  int                tail_idx = 0;
  logic              shadow_empty = 1'b1;
  logic [CAP_W-1:0]  shadow_cap = CAP_W'(1024);

  deque_result_t pending_results[$];

  int mismatch_count = 0;
  int requests_sent = 0;
  int results_checked = 0;
  int full_refusals = 0;
  int empty_refusals = 0;
  int capacity_writes = 0;

  // Sender and receiver pacing.
  int   tx_burst = 0;
  logic tx_steady = 1'b0;
  logic rx_steady = 1'b0;
  int   rx_left = 0;
  logic rx_open = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Timed out with %0d results outstanding.", pending_results.size());
    $display("CHECK FAILED");
    $finish;
  end

  function automatic int wrap_next(int i, int cap);
    return (i + 1 >= cap) ? 0 : i + 1;
  endfunction

  function automatic int wrap_prev(int i, int cap);
    if (i == 0 || i > cap) return cap - 1;
    return i - 1;
  endfunction

  // Apply one request to the shadow deque and queue the beat it should produce.
  function void apply_request(logic [1:0] kind, logic [DATA_W-1:0] word);
    deque_result_t r;
    int            cap;
    cap = (shadow_cap == 0) ? 1 : (shadow_cap > DEPTH) ? DEPTH : int'(shadow_cap);
    r = '0;
    r.status = STAT_DONE;
    if (kind == REQ_PUSH_REAR || kind == REQ_PUSH_FRONT) begin
      if (!shadow_empty && wrap_next(tail_idx, cap) == head_idx) begin
        r.status = STAT_FULL;
        full_refusals++;
      end else if (shadow_empty) begin
        head_idx = 0;
        tail_idx = 0;
        shadow_empty = 1'b0;
        shadow_slots[0] = word;
      end else if (kind == REQ_PUSH_REAR) begin
        tail_idx = wrap_next(tail_idx, cap);
        shadow_slots[tail_idx] = word;
      end else begin
        head_idx = wrap_prev(head_idx, cap);
        shadow_slots[head_idx] = word;
      end
    end else begin
      if (shadow_empty) begin
        r.status = STAT_EMPTY;
        empty_refusals++;
      end else begin
        r.popped = shadow_slots[(kind == REQ_POP_FRONT) ? head_idx : tail_idx];
        if (head_idx == tail_idx) begin
          head_idx = 0;
          tail_idx = 0;
          shadow_empty = 1'b1;
        end else if (kind == REQ_POP_FRONT) begin
          head_idx = wrap_next(head_idx, cap);
        end else begin
          tail_idx = wrap_prev(tail_idx, cap);
        end
      end
    end
    if (!shadow_empty) begin
      r.head = shadow_slots[head_idx];
      r.tail = shadow_slots[tail_idx];
    end
    r.empty = shadow_empty;
    pending_results.push_back(r);
  endfunction

  // Receiver: alternating runs of ready and stall of random length, or always ready when steady.
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_open = ~rx_open;
      rx_left = rx_open ? $urandom_range(1, 16) : $urandom_range(1, 10);
    end
    rx_left = rx_left - 1;
    m_tready <= rx_steady | rx_open;
  end

  // Compare every result beat with the oldest prediction.
  always @(posedge clk) begin
    deque_result_t want;
    deque_result_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.status = m_tuser;
      got.popped = m_tdata[31:0];
      got.head   = m_tdata[63:32];
      got.tail   = m_tdata[95:64];
      got.empty  = m_tdata[96];
      results_checked++;
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("Unexpected result beat: status %0d popped %h head %h tail %h empty %b",
                   got.status, got.popped, got.head, got.tail, got.empty);
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status || got.popped !== want.popped ||
            got.head !== want.head || got.tail !== want.tail ||
            got.empty !== want.empty || m_tdata[M_DATA_W-1:RES_BITS] !== '0) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("Mismatch on result %0d:", results_checked);
            $display("  expected status %0d popped %h head %h tail %h empty %b",
                     want.status, want.popped, want.head, want.tail, want.empty);
            $display("  actual   status %0d popped %h head %h tail %h empty %b pad %h",
                     got.status, got.popped, got.head, got.tail, got.empty,
                     m_tdata[M_DATA_W-1:RES_BITS]);
          end
        end
      end
    end
  end

  // Send one request beat, with random gaps between bursts unless pacing is steady.
  task automatic send_req(input logic [1:0] kind, input logic [DATA_W-1:0] word);
    int gap;
    if (tx_burst == 0) begin
      tx_burst = $urandom_range(1, 30);
      if (!tx_steady) begin
        gap = $urandom_range(1, 6);
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= word;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    apply_request(kind, word);
    requests_sent++;
    tx_burst--;
  endtask

  // Stop sending and wait until every predicted beat has arrived.
  task automatic settle();
    s_tvalid <= 1'b0;
    tx_burst = 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] value);
    settle();
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    shadow_cap   = value;
    head_idx     = 0;
    tail_idx     = 0;
    shadow_empty = 1'b1;
    capacity_writes++;
  endtask

  function automatic logic [DATA_W-1:0] pick_word();
    case ($urandom_range(0, 9))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'hffff_ffff;
      3: return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [1:0] pick_req(int push_pct);
    if ($urandom_range(0, 99) < push_pct)
      return $urandom_range(0, 1) ? REQ_PUSH_FRONT : REQ_PUSH_REAR;
    return $urandom_range(0, 1) ? REQ_POP_REAR : REQ_POP_FRONT;
  endfunction

  // Pops on an empty deque, pushes of the extreme words at the reset capacity, and pops back to empty.
  task automatic test_empty_and_extremes();
    send_req(REQ_POP_FRONT, 32'h0);
    send_req(REQ_POP_REAR, 32'hffff_ffff);
    send_req(REQ_PUSH_REAR, 32'h7fff_ffff);
    send_req(REQ_PUSH_FRONT, 32'h8000_0000);
    send_req(REQ_PUSH_REAR, 32'h0000_0000);
    send_req(REQ_PUSH_FRONT, 32'hffff_ffff);
    send_req(REQ_POP_REAR, 32'h0);
    send_req(REQ_POP_FRONT, 32'h0);
    send_req(REQ_POP_REAR, 32'h0);
    send_req(REQ_POP_FRONT, 32'h0);
    send_req(REQ_POP_FRONT, 32'h0);
  endtask

  // Smallest capacities, out-of-range capacities and a write that empties the deque.
  task automatic test_capacity_edges();
    write_capacity(CAP_W'(1));
    send_req(REQ_PUSH_FRONT, 32'h1234_5678);
    send_req(REQ_PUSH_REAR, 32'hdead_beef);
    send_req(REQ_PUSH_FRONT, 32'h5555_aaaa);
    send_req(REQ_POP_REAR, 32'h0);
    write_capacity(CAP_W'(2));
    send_req(REQ_PUSH_FRONT, 32'h0000_0001);
    send_req(REQ_PUSH_FRONT, 32'h0000_0002);
    send_req(REQ_PUSH_REAR, 32'h0000_0003);
    send_req(REQ_POP_FRONT, 32'h0);
    send_req(REQ_POP_FRONT, 32'h0);
    write_capacity(CAP_W'(0));
    send_req(REQ_PUSH_REAR, 32'haaaa_5555);
    send_req(REQ_PUSH_REAR, 32'h0f0f_f0f0);
    write_capacity({CAP_W{1'b1}});
    send_req(REQ_POP_REAR, 32'h0);
  endtask

  // Fill the largest store to the full refusal, from both ends.
  task automatic test_fill_largest();
    write_capacity(CAP_W'(DEPTH));
    repeat (DEPTH) send_req($urandom_range(0, 1) ? REQ_PUSH_FRONT : REQ_PUSH_REAR,
                            pick_word());
    send_req(REQ_PUSH_REAR, pick_word());
    send_req(REQ_PUSH_FRONT, pick_word());
    repeat (12) send_req($urandom_range(0, 1) ? REQ_POP_REAR : REQ_POP_FRONT, 32'h0);
  endtask

  // Random request mixes over a series of capacities; the push share swings so
  // that small stores bounce between full and empty.
  task automatic test_random_phases();
    logic [CAP_W-1:0] caps [12];
    int               push_pct;
    caps = '{CAP_W'(1), CAP_W'(2), CAP_W'(3), CAP_W'(0), CAP_W'(5), CAP_W'(8),
             {CAP_W{1'b1}}, CAP_W'(1024), CAP_W'($urandom_range(4, 64)),
             CAP_W'($urandom_range(1, 2047)), CAP_W'(16), CAP_W'(7)};
    foreach (caps[p]) begin
      write_capacity(caps[p]);
      tx_steady  = ($urandom_range(0, 3) == 0);
      rx_steady <= ($urandom_range(0, 3) == 0);
      repeat (3) begin
        case ($urandom_range(0, 2))
          0: push_pct = 25;
          1: push_pct = 50;
          default: push_pct = 80;
        endcase
        repeat (4) send_req(pick_req(push_pct), pick_word());
      end
    end
    tx_steady  = 1'b0;
    rx_steady <= 1'b0;
  endtask

  initial begin
    int waited;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_and_extremes();
    test_capacity_edges();
    test_fill_largest();
    test_random_phases();

    s_tvalid <= 1'b0;
    waited = 0;
    while (waited < 5000 && pending_results.size() != 0) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);

    $display("Sent %0d requests over %0d capacity settings; %0d results checked.",
             requests_sent, capacity_writes, results_checked);
    $display("Full refusals %0d, empty refusals %0d, mismatches %0d, left over %0d.",
             full_refusals, empty_refusals, mismatch_count, pending_results.size());
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
